// ===== rtl/m2m_pkg.sv =====
// Shared types, constants and helper functions for the MUS to MIDI converter.
`default_nettype none
package m2m_pkg;

  localparam int unsigned CHANNELS = 16;
  localparam int unsigned CHAN_W   = $clog2(CHANNELS);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       score_start;
  } in_word_t;

  typedef struct packed {
    logic [31:0] delta_ticks;
    logic [7:0]  status_byte;
    logic [7:0]  data_one;
    logic [7:0]  data_two;
    logic        score_end;
    logic        bad_controller;
  } out_word_t;

  typedef enum logic [1:0] {
    PH_DESC   = 2'd0,
    PH_PARAM1 = 2'd1,
    PH_PARAM2 = 2'd2,
    PH_DELAY  = 2'd3
  } phase_t;

  typedef struct packed {
    logic              rd_en;
    logic [CHAN_W-1:0] rd_addr;
    logic              wr_en;
    logic [CHAN_W-1:0] wr_addr;
    logic [7:0]        wr_data;
  } vol_req_t;

  localparam logic [2:0] KIND_RELEASE = 3'd0;
  localparam logic [2:0] KIND_PLAY    = 3'd1;
  localparam logic [2:0] KIND_PITCH   = 3'd2;
  localparam logic [2:0] KIND_SYSTEM  = 3'd3;
  localparam logic [2:0] KIND_END     = 3'd5;

  localparam logic [7:0] ST_NOTE_OFF = 8'h80;
  localparam logic [7:0] ST_NOTE_ON  = 8'h90;
  localparam logic [7:0] ST_CTRL     = 8'hb0;
  localparam logic [7:0] ST_PROGRAM  = 8'hc0;
  localparam logic [7:0] ST_BEND     = 8'he0;

  localparam logic [7:0] VEL_MAX     = 8'd127;
  localparam logic [7:0] VOL_RESET   = 8'd64;
  localparam logic [7:0] CTRL_LIMIT  = 8'd15;

  localparam logic [CHAN_W-1:0] CH_PERC = 4'd9;
  localparam logic [CHAN_W-1:0] CH_LAST = 4'd15;

  localparam logic [2:0] REG_VOLUME_SHIFT = 3'd0;

  function automatic logic [7:0] ctrl_map(input logic [7:0] num);
    logic [7:0] r;
    case (num)
      8'd0:    r = 8'd0;
      8'd1:    r = 8'd0;
      8'd2:    r = 8'd1;
      8'd3:    r = 8'd7;
      8'd4:    r = 8'd10;
      8'd5:    r = 8'd11;
      8'd6:    r = 8'd91;
      8'd7:    r = 8'd93;
      8'd8:    r = 8'd64;
      8'd9:    r = 8'd67;
      8'd10:   r = 8'd120;
      8'd11:   r = 8'd123;
      8'd12:   r = 8'd126;
      8'd13:   r = 8'd127;
      8'd14:   r = 8'd121;
      default: r = 8'd0;
    endcase
    return r;
  endfunction

  function automatic logic [CHAN_W-1:0] chan_remap(input logic [CHAN_W-1:0] ch);
    logic [CHAN_W-1:0] r;
    if (ch == CH_LAST) begin
      r = CH_PERC;
    end else if (ch == CH_PERC) begin
      r = CH_LAST;
    end else begin
      r = ch;
    end
    return r;
  endfunction

  function automatic logic [7:0] velocity(input logic [7:0] vol, input logic [2:0] shift);
    logic [14:0] w;
    w = {7'd0, vol} << shift;
    return (w > 15'(VEL_MAX)) ? VEL_MAX : w[7:0];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/mus_to_midi_event_converter_unit.sv =====
// Top level: MUS score byte stream in, MIDI short event words out.
// A result word is registered and valid in the cycle after its last byte is taken.
// Throughput: one byte per cycle unless the output stalls; the volume memory is read
// on the descriptor byte and its registered data is used by the next parameter byte.
// Reset (rst_n low, synchronous): parser idle, delay cleared, volume_shift zero,
// every channel volume reads 64 at once through per-entry valid bits.
`default_nettype none
module mus_to_midi_event_converter_unit (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire m2m_pkg::in_word_t  in_word,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output m2m_pkg::out_word_t      out_word,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  logic [2:0]        volume_shift_r;
  m2m_pkg::vol_req_t vol_req;
  logic [7:0]        vol_rd_data;
  logic              reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = ({paddr[2], 2'b00} == m2m_pkg::REG_VOLUME_SHIFT);
  assign prdata  = reg_sel ? {29'd0, volume_shift_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      volume_shift_r <= '0;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      volume_shift_r <= pwdata[2:0];
    end
  end

  m2m_parse u_parse (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_word      (in_word),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_word     (out_word),
    .volume_shift (volume_shift_r),
    .vol_rd_data  (vol_rd_data),
    .vol_req      (vol_req)
  );

  m2m_vol_ram u_vol_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (vol_req),
    .rd_data (vol_rd_data)
  );

endmodule
`default_nettype wire

// ===== rtl/m2m_vol_ram.sv =====
// Per-channel volume memory with registered read and reset-valid bits.
`default_nettype none
module m2m_vol_ram (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire m2m_pkg::vol_req_t req,
  output logic [7:0]            rd_data
);

  logic [7:0]                   mem [m2m_pkg::CHANNELS];
  logic [m2m_pkg::CHANNELS-1:0] valid_r;
  logic [7:0]                   rd_data_r;
  logic [m2m_pkg::CHAN_W-1:0]   wa;
  logic [m2m_pkg::CHAN_W-1:0]   ra;

  assign wa = req.wr_addr;
  assign ra = req.rd_addr;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[wa] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= valid_r[ra] ? mem[ra] : m2m_pkg::VOL_RESET;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (req.wr_en) begin
      valid_r[wa] <= 1'b1;
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

// ===== rtl/m2m_parse.sv =====
// Score byte parser with phase machine and registered output word.
`default_nettype none
module m2m_parse (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire m2m_pkg::in_word_t    in_word,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output m2m_pkg::out_word_t        out_word,
  input  wire logic [2:0]           volume_shift,
  input  wire logic [7:0]           vol_rd_data,
  output m2m_pkg::vol_req_t         vol_req
);

  m2m_pkg::phase_t    phase_r, phase_nxt, ph;
  logic [2:0]         kind_r, kind_nxt, dkind;
  logic [3:0]         chan_r, chan_nxt;
  logic               last_r, last_nxt;
  logic [7:0]         first_r, first_nxt;
  logic [31:0]        delta_r, delta_nxt, dl;
  logic               done_r, done_nxt, dn;
  logic               out_valid_r;
  m2m_pkg::out_word_t out_word_r;
  m2m_pkg::out_word_t res;
  logic               res_v;
  logic               fire;
  logic [7:0]         b;
  logic [7:0]         fin_st, fin_d1, fin_d2;
  logic               fin_bad, fin;

  assign in_ready = !out_valid_r || out_ready;
  assign fire     = in_valid && in_ready;
  assign b        = in_word.data_byte;

  always_comb begin
    ph        = in_word.score_start ? m2m_pkg::PH_DESC : phase_r;
    dl        = in_word.score_start ? 32'd0 : delta_r;
    dn        = in_word.score_start ? 1'b0 : done_r;
    dkind     = b[6:4];
    phase_nxt = ph;
    kind_nxt  = kind_r;
    chan_nxt  = chan_r;
    last_nxt  = last_r;
    first_nxt = first_r;
    delta_nxt = dl;
    done_nxt  = dn;
    res       = '0;
    res_v     = 1'b0;
    fin       = 1'b0;
    fin_st    = '0;
    fin_d1    = '0;
    fin_d2    = '0;
    fin_bad   = 1'b0;
    vol_req   = '0;
    vol_req.rd_addr = b[3:0];
    vol_req.wr_addr = chan_r;
    vol_req.wr_data = b;
    if (!dn) begin
      case (ph)
        m2m_pkg::PH_DESC: begin
          chan_nxt      = b[3:0];
          kind_nxt      = dkind;
          last_nxt      = b[7];
          vol_req.rd_en = 1'b1;
          if (dkind >= m2m_pkg::KIND_END) begin
            res_v           = 1'b1;
            res.score_end   = 1'b1;
            done_nxt        = 1'b1;
            phase_nxt       = m2m_pkg::PH_DESC;
          end else begin
            phase_nxt = m2m_pkg::PH_PARAM1;
          end
        end
        m2m_pkg::PH_PARAM1: begin
          case (kind_r)
            m2m_pkg::KIND_RELEASE: begin
              fin    = 1'b1;
              fin_st = m2m_pkg::ST_NOTE_OFF;
              fin_d1 = b;
            end
            m2m_pkg::KIND_PLAY: begin
              first_nxt = b;
              if (b[7]) begin
                phase_nxt = m2m_pkg::PH_PARAM2;
              end else begin
                fin    = 1'b1;
                fin_st = m2m_pkg::ST_NOTE_ON;
                fin_d1 = {1'b0, b[6:0]};
                fin_d2 = m2m_pkg::velocity(vol_rd_data, volume_shift);
              end
            end
            m2m_pkg::KIND_PITCH: begin
              fin    = 1'b1;
              fin_st = m2m_pkg::ST_BEND;
              fin_d1 = {1'b0, b[0], 6'd0};
              fin_d2 = {1'b0, b[7:1]};
            end
            m2m_pkg::KIND_SYSTEM: begin
              fin     = 1'b1;
              fin_st  = m2m_pkg::ST_CTRL;
              fin_d1  = m2m_pkg::ctrl_map(b);
              fin_bad = (b >= m2m_pkg::CTRL_LIMIT);
            end
            default: begin
              first_nxt = b;
              phase_nxt = m2m_pkg::PH_PARAM2;
            end
          endcase
        end
        m2m_pkg::PH_PARAM2: begin
          fin = 1'b1;
          if (kind_r == m2m_pkg::KIND_PLAY) begin
            vol_req.wr_en = 1'b1;
            fin_st = m2m_pkg::ST_NOTE_ON;
            fin_d1 = {1'b0, first_r[6:0]};
            fin_d2 = m2m_pkg::velocity(b, volume_shift);
          end else if (first_r == 8'd0) begin
            fin_st = m2m_pkg::ST_PROGRAM;
            fin_d1 = b;
          end else begin
            fin_st  = m2m_pkg::ST_CTRL;
            fin_d1  = m2m_pkg::ctrl_map(first_r);
            fin_d2  = b;
            fin_bad = (first_r >= m2m_pkg::CTRL_LIMIT);
          end
        end
        m2m_pkg::PH_DELAY: begin
          delta_nxt = {dl[24:0], b[6:0]};
          if (!b[7]) begin
            phase_nxt = m2m_pkg::PH_DESC;
          end
        end
        default: begin
          phase_nxt = m2m_pkg::PH_DESC;
        end
      endcase
      if (fin) begin
        res_v              = 1'b1;
        res.delta_ticks    = dl;
        res.status_byte    = fin_st | {4'd0, m2m_pkg::chan_remap(chan_r)};
        res.data_one       = fin_d1;
        res.data_two       = fin_d2;
        res.bad_controller = fin_bad;
        delta_nxt          = 32'd0;
        phase_nxt          = last_r ? m2m_pkg::PH_DELAY : m2m_pkg::PH_DESC;
      end
    end
    vol_req.rd_en = vol_req.rd_en && fire;
    vol_req.wr_en = vol_req.wr_en && fire;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= m2m_pkg::PH_DESC;
      kind_r      <= '0;
      chan_r      <= '0;
      last_r      <= 1'b0;
      first_r     <= '0;
      delta_r     <= '0;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (fire) begin
      phase_r     <= phase_nxt;
      kind_r      <= kind_nxt;
      chan_r      <= chan_nxt;
      last_r      <= last_nxt;
      first_r     <= first_nxt;
      delta_r     <= delta_nxt;
      done_r      <= done_nxt;
      out_valid_r <= res_v;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res_v) begin
      out_word_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule
`default_nettype wire

// ===== rtl/m2m_chk.sv =====
// Port-level checker for the converter, bound to the top level.
`default_nettype none
module m2m_chk (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire m2m_pkg::out_word_t out_word
);

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_word))
    else $error("stalled word changed");

  a_end_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.score_end |->
      out_word.delta_ticks == 32'd0 && out_word.status_byte == 8'd0 &&
      out_word.data_one == 8'd0 && out_word.data_two == 8'd0 &&
      !out_word.bad_controller)
    else $error("end word carries data");

  a_bad_ctrl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.bad_controller |->
      out_word.status_byte[7:4] == m2m_pkg::ST_CTRL[7:4] && out_word.data_one == 8'd0)
    else $error("bad controller flag on non-controller word");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

endmodule

bind mus_to_midi_event_converter_unit m2m_chk u_m2m_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_word  (out_word)
);
`default_nettype wire

// ===== test/tb.sv =====
// Testbench for the MUS to MIDI converter: directed table, then random scores.
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WATCHDOG_LIMIT  = 3000;
  localparam int unsigned HOLD_CYCLES     = 300;
  localparam int unsigned SETTLE_CYCLES   = 4;
  localparam int unsigned ITEMS_PER_PHASE = 170;
  localparam int unsigned PHASES          = 6;

  localparam logic [2:0] KIND_CONTROLLER   = 3'd4;
  localparam logic [2:0] VOLUME_SHIFT_ADDR = 3'(4 * m2m_pkg::REG_VOLUME_SHIFT);

  localparam logic [7:0] MIDI_CTRL [15] = '{
    8'd0, 8'd0, 8'd1, 8'd7, 8'd10, 8'd11, 8'd91, 8'd93,
    8'd64, 8'd67, 8'd120, 8'd123, 8'd126, 8'd127, 8'd121
  };

  localparam logic [2:0] SHIFT_PLAN [PHASES] = '{3'd7, 3'd0, 3'd3, 3'd1, 3'd5, 3'd7};

  typedef struct packed {
    logic [7:0]         data;
    logic               start;
    logic               typed;
    logic               has;
    m2m_pkg::out_word_t result;
  } stim_row_t;

  localparam m2m_pkg::out_word_t NO_EVENT  = '0;
  localparam m2m_pkg::out_word_t END_EVENT = '{32'd0, 8'd0, 8'd0, 8'd0, 1'b1, 1'b0};

  localparam stim_row_t DIRECTED [27] = '{
    '{8'h10, 1'b1, 1'b1, 1'b0, NO_EVENT},
    '{8'h3c, 1'b0, 1'b1, 1'b1, '{32'd0, 8'h90, 8'h3c, 8'h40, 1'b0, 1'b0}},
    '{8'h89, 1'b0, 1'b1, 1'b0, NO_EVENT},
    '{8'hff, 1'b0, 1'b1, 1'b1, '{32'd0, 8'h8f, 8'hff, 8'h00, 1'b0, 1'b0}},
    '{8'h81, 1'b0, 1'b1, 1'b0, NO_EVENT},
    '{8'h80, 1'b0, 1'b1, 1'b0, NO_EVENT},
    '{8'h05, 1'b0, 1'b1, 1'b0, NO_EVENT},
    '{8'h2f, 1'b0, 1'b1, 1'b0, NO_EVENT},
    '{8'hff, 1'b0, 1'b1, 1'b1, '{32'd16389, 8'he9, 8'h40, 8'h7f, 1'b0, 1'b0}},
    '{8'h33, 1'b0, 1'b1, 1'b0, NO_EVENT},
    '{8'h0f, 1'b0, 1'b1, 1'b1, '{32'd0, 8'hb3, 8'h00, 8'h00, 1'b0, 1'b1}},
    '{8'h45, 1'b0, 1'b0, 1'b0, NO_EVENT},
    '{8'h00, 1'b0, 1'b0, 1'b0, NO_EVENT},
    '{8'h7f, 1'b0, 1'b0, 1'b0, NO_EVENT},
    '{8'h46, 1'b0, 1'b0, 1'b0, NO_EVENT},
    '{8'hff, 1'b0, 1'b0, 1'b0, NO_EVENT},
    '{8'hff, 1'b0, 1'b0, 1'b0, NO_EVENT},
    '{8'h12, 1'b0, 1'b0, 1'b0, NO_EVENT},
    '{8'h85, 1'b0, 1'b0, 1'b0, NO_EVENT},
    '{8'hff, 1'b0, 1'b0, 1'b0, NO_EVENT},
    '{8'h10, 1'b0, 1'b0, 1'b0, NO_EVENT},
    '{8'h60, 1'b1, 1'b1, 1'b1, END_EVENT},
    '{8'h10, 1'b0, 1'b1, 1'b0, NO_EVENT},
    '{8'h50, 1'b1, 1'b1, 1'b1, END_EVENT},
    '{8'h70, 1'b1, 1'b1, 1'b1, END_EVENT},
    '{8'h00, 1'b1, 1'b1, 1'b0, NO_EVENT},
    '{8'h00, 1'b0, 1'b1, 1'b1, '{32'd0, 8'h80, 8'h00, 8'h00, 1'b0, 1'b0}}
  };

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  m2m_pkg::in_word_t  in_word   = '0;
  logic               out_ready = 1'b0;
  logic               psel      = 1'b0;
  logic               penable   = 1'b0;
  logic               pwrite    = 1'b0;
  logic [2:0]         paddr     = '0;
  logic [31:0]        pwdata    = '0;
  logic               in_ready;
  logic               out_valid;
  m2m_pkg::out_word_t out_word;
  logic [31:0]        prdata;
  logic               pready;

  mus_to_midi_event_converter_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #5 clk = ~clk;

  // predictor state
  m2m_pkg::phase_t parse_at   = m2m_pkg::PH_DESC;
  logic [2:0]      cur_kind   = '0;
  logic [3:0]      cur_chan   = '0;
  logic            cur_last   = 1'b0;
  logic [7:0]      held_param = '0;
  logic [31:0]     delay_acc  = '0;
  logic [7:0]      chan_vol [m2m_pkg::CHANNELS];
  logic            score_over = 1'b0;
  logic [2:0]      vel_shift  = '0;

  m2m_pkg::out_word_t expected_events [$];
  m2m_pkg::out_word_t want_word;

  int fail_count     = 0;
  int events_checked = 0;
  int bytes_taken    = 0;
  int send_idle_pct  = 17;
  int recv_idle_pct  = 77;
  int hold_reqs      = 0;
  int hold_seen      = 0;
  int hold_left      = 0;
  int stall_cycles   = 0;
  logic need_start   = 1'b0;

  function automatic logic [7:0] rand_byte();
    return 8'($urandom);
  endfunction

  function automatic stim_row_t free_row(input logic [7:0] b, input logic s);
    return '{b, s, 1'b0, 1'b0, '0};
  endfunction

  function automatic logic [7:0] note_velocity(input logic [7:0] vol);
    logic [14:0] scaled;
    scaled = {7'd0, vol} << vel_shift;
    return (scaled > 15'(m2m_pkg::VEL_MAX)) ? m2m_pkg::VEL_MAX : scaled[7:0];
  endfunction

  // {bad, midi controller}
  function automatic logic [8:0] midi_controller(input logic [7:0] num);
    if (num >= m2m_pkg::CTRL_LIMIT) begin
      return {1'b1, 8'd0};
    end
    return {1'b0, MIDI_CTRL[num[3:0]]};
  endfunction

  task automatic close_event(input logic [7:0] status, input logic [7:0] d1,
                             input logic [7:0] d2, input logic bad,
                             output m2m_pkg::out_word_t evt);
    logic [3:0] ch;
    ch = cur_chan;
    if (ch == m2m_pkg::CH_LAST) begin
      ch = m2m_pkg::CH_PERC;
    end else if (ch == m2m_pkg::CH_PERC) begin
      ch = m2m_pkg::CH_LAST;
    end
    evt = '{delay_acc, status | {4'd0, ch}, d1, d2, 1'b0, bad};
    delay_acc = '0;
    parse_at = cur_last ? m2m_pkg::PH_DELAY : m2m_pkg::PH_DESC;
  endtask

  task automatic convert_byte(input m2m_pkg::in_word_t w, output logic fired,
                              output m2m_pkg::out_word_t evt, output logic skipped);
    logic [7:0] b;
    logic [8:0] ctl;
    b = w.data_byte;
    fired = 1'b0;
    skipped = 1'b0;
    evt = '0;
    if (w.score_start) begin
      parse_at = m2m_pkg::PH_DESC;
      delay_acc = '0;
      score_over = 1'b0;
    end
    if (score_over) begin
      skipped = 1'b1;
      return;
    end
    case (parse_at)
      m2m_pkg::PH_DESC: begin
        cur_chan = b[3:0];
        cur_kind = b[6:4];
        cur_last = b[7];
        if (cur_kind >= m2m_pkg::KIND_END) begin
          evt = END_EVENT;
          fired = 1'b1;
          score_over = 1'b1;
        end else begin
          parse_at = m2m_pkg::PH_PARAM1;
        end
      end
      m2m_pkg::PH_PARAM1: begin
        case (cur_kind)
          m2m_pkg::KIND_RELEASE: begin
            close_event(m2m_pkg::ST_NOTE_OFF, b, 8'd0, 1'b0, evt);
            fired = 1'b1;
          end
          m2m_pkg::KIND_PLAY: begin
            held_param = b;
            if (b[7]) begin
              parse_at = m2m_pkg::PH_PARAM2;
            end else begin
              close_event(m2m_pkg::ST_NOTE_ON, {1'b0, b[6:0]},
                          note_velocity(chan_vol[cur_chan]), 1'b0, evt);
              fired = 1'b1;
            end
          end
          m2m_pkg::KIND_PITCH: begin
            close_event(m2m_pkg::ST_BEND, {1'b0, b[0], 6'd0}, {1'b0, b[7:1]}, 1'b0, evt);
            fired = 1'b1;
          end
          m2m_pkg::KIND_SYSTEM: begin
            ctl = midi_controller(b);
            close_event(m2m_pkg::ST_CTRL, ctl[7:0], 8'd0, ctl[8], evt);
            fired = 1'b1;
          end
          default: begin
            held_param = b;
            parse_at = m2m_pkg::PH_PARAM2;
          end
        endcase
      end
      m2m_pkg::PH_PARAM2: begin
        fired = 1'b1;
        if (cur_kind == m2m_pkg::KIND_PLAY) begin
          chan_vol[cur_chan] = b;
          close_event(m2m_pkg::ST_NOTE_ON, {1'b0, held_param[6:0]}, note_velocity(b), 1'b0,
                      evt);
        end else if (held_param == 8'd0) begin
          close_event(m2m_pkg::ST_PROGRAM, b, 8'd0, 1'b0, evt);
        end else begin
          ctl = midi_controller(held_param);
          close_event(m2m_pkg::ST_CTRL, ctl[7:0], b, ctl[8], evt);
        end
      end
      default: begin
        delay_acc = {delay_acc[24:0], b[6:0]};
        if (!b[7]) begin
          parse_at = m2m_pkg::PH_DESC;
        end
      end
    endcase
  endtask

  task automatic send_word(input stim_row_t row);
    m2m_pkg::in_word_t  w;
    logic               fired, skipped;
    m2m_pkg::out_word_t evt;
    w.data_byte = row.data;
    w.score_start = row.start;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (!in_ready);
    convert_byte(w, fired, evt, skipped);
    if (row.typed) begin
      if (row.has) expected_events.push_back(row.result);
    end else if (fired) begin
      expected_events.push_back(evt);
    end
    if (!skipped) bytes_taken++;
  endtask

  task automatic send_random_event();
    int pick, n;
    logic s, last;
    logic [2:0] kind;
    logic [3:0] chan;
    logic [7:0] first;
    s = need_start || ($urandom_range(99) < 3);
    need_start = 1'b0;
    pick = $urandom_range(99);
    if (pick < 4) begin
      // noise, possibly abandoning a partial event
      n = $urandom_range(1, 4);
      repeat (n) send_word(free_row(rand_byte(), ($urandom_range(7) == 0)));
      need_start = 1'b1;
    end else if (pick < 7) begin
      send_word(free_row({1'($urandom_range(1)), 3'($urandom_range(5, 7)),
                          4'($urandom_range(15))}, s));
      n = $urandom_range(0, 3);
      repeat (n) send_word(free_row(rand_byte(), 1'b0));
      need_start = 1'b1;
    end else begin
      kind = 3'($urandom_range(4));
      chan = 4'($urandom_range(15));
      last = ($urandom_range(99) < 35);
      send_word(free_row({last, kind, chan}, s));
      case (kind)
        m2m_pkg::KIND_PLAY: begin
          if ($urandom_range(1) == 1) begin
            send_word(free_row({1'b1, 7'($urandom_range(127))}, 1'b0));
            send_word(free_row(($urandom_range(3) == 0) ? rand_byte() : 8'($urandom_range(31)),
                               1'b0));
          end else begin
            send_word(free_row({1'b0, 7'($urandom_range(127))}, 1'b0));
          end
        end
        m2m_pkg::KIND_SYSTEM: begin
          send_word(free_row(($urandom_range(3) == 0) ? 8'($urandom_range(15, 255))
                                                      : 8'($urandom_range(14)), 1'b0));
        end
        KIND_CONTROLLER: begin
          if ($urandom_range(3) == 0) begin
            first = 8'd0;
          end else if ($urandom_range(4) == 0) begin
            first = 8'($urandom_range(15, 255));
          end else begin
            first = 8'($urandom_range(1, 14));
          end
          send_word(free_row(first, 1'b0));
          send_word(free_row(rand_byte(), 1'b0));
        end
        default: begin
          send_word(free_row(rand_byte(), 1'b0));
        end
      endcase
      if (last) begin
        n = ($urandom_range(7) == 0) ? $urandom_range(5, 7) : $urandom_range(1, 2);
        repeat (n - 1) send_word(free_row({1'b1, 7'($urandom_range(127))}, 1'b0));
        send_word(free_row({1'b0, 7'($urandom_range(127))}, 1'b0));
      end
    end
  endtask

  task automatic drain_events();
    in_valid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_shift(input logic [2:0] v);
    logic [31:0] rd;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= VOLUME_SHIFT_ADDR;
    pwdata <= {29'd0, v};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    vel_shift = v;
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    if (rd !== {29'd0, v}) begin
      $display("%0t: volume_shift readback mismatch, expected 0x%0h, got 0x%0h", $time,
               {29'd0, v}, rd);
      fail_count++;
    end
  endtask

  task automatic compare_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_seen != hold_reqs) begin
      hold_seen <= hold_reqs;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_events.size() == 0) begin
        $display("%0t: unexpected event word, expected none, got 0x%0h", $time, out_word);
        fail_count++;
      end else begin
        want_word = expected_events.pop_front();
        compare_field("delta_ticks", want_word.delta_ticks, out_word.delta_ticks);
        compare_field("status_byte", 32'(want_word.status_byte), 32'(out_word.status_byte));
        compare_field("data_one", 32'(want_word.data_one), 32'(out_word.data_one));
        compare_field("data_two", 32'(want_word.data_two), 32'(out_word.data_two));
        compare_field("score_end", 32'(want_word.score_end), 32'(out_word.score_end));
        compare_field("bad_controller", 32'(want_word.bad_controller),
                      32'(out_word.bad_controller));
        events_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no progress for %0d cycles, %0d events outstanding", $time,
               stall_cycles, expected_events.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    for (int c = 0; c < int'(m2m_pkg::CHANNELS); c++) chan_vol[c] = m2m_pkg::VOL_RESET;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    program_shift(3'd0);
    foreach (DIRECTED[i]) send_word(DIRECTED[i]);
    drain_events();
    for (int p = 0; p < PHASES; p++) begin
      case (p / 2)
        0: begin
          send_idle_pct = 17;
          recv_idle_pct = 77;
        end
        1: begin
          send_idle_pct = 77;
          recv_idle_pct = 17;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      program_shift(SHIFT_PLAN[p]);
      if (p == 1) hold_reqs++;
      while (bytes_taken < (p + 1) * ITEMS_PER_PHASE + $size(DIRECTED)) send_random_event();
      drain_events();
    end
    $display("Covered %0d parsed score bytes and %0d MIDI event words,", bytes_taken,
             events_checked);
    $display("over %0d volume shift writes with sender and receiver stalls and a long hold.",
             PHASES + 1);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
`default_nettype wire
